### rtl/core/cgt_pkg.sv
// Shared types, codes and defaults of the correlation group tracker.
package cgt_pkg;

  localparam int unsigned NUM_GROUPS_DEF     = 16;
  localparam int unsigned MAX_GROUP_SIZE_DEF = 16;

  localparam int unsigned ID_W     = 64;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] GROUP_SIZE_RST     = 5'd16;
  localparam logic [CFG_W-1:0] GROUPS_ENABLED_RST = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_ENABLED = 2'd1;

  localparam logic FUNC_ADD     = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_CAPACITY  = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  // Result fields, status in the lowest bits.
  typedef struct packed {
    logic [4:0] groups_in_use;
    logic [4:0] member_count;
    logic [3:0] position;
    logic [3:0] group_slot;
    logic       complete;
    status_e    status;
  } result_t;

  localparam int unsigned RES_W   = $bits(result_t);
  localparam int unsigned OUT_D_W = ((RES_W + 7) / 8) * 8;

endpackage

### rtl/core/cgt_slot_ram.sv
// Slot table memory: one write port, one registered read port.
module cgt_slot_ram
  import cgt_pkg::*;
#(
  parameter int unsigned DEPTH = NUM_GROUPS_DEF,
  parameter int unsigned WIDTH = ID_W + 5
) (
  input  logic                                       clk_i,
  input  logic                                       rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                           rd_data_o,
  input  logic                                       wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                           wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/correlation_group_tracker.sv
// Correlation group tracker: one request in, one result out, per request scan of the slot table.
//
// Each request walks the enabled slots through the slot table memory, one slot read per
// cycle, looking for the matching key and the lowest free slot; a key match ends the walk
// early. A request's time from acceptance to result grows with groups_enabled, and is shorter
// when the key matches a low slot; a zero id skips the walk and goes straight to the decision.
// The registered memory read and the slot walk set this time. The next request is taken
// as soon as the result sits in the output register. Keys and counts live in the memory;
// per-slot used bits are flip-flops cleared by reset, so no clearing pass is needed.
// Configuration is always ready; write only while no request is in flight.
module correlation_group_tracker
  import cgt_pkg::*;
#(
  parameter int unsigned NUM_GROUPS     = NUM_GROUPS_DEF,
  parameter int unsigned MAX_GROUP_SIZE = MAX_GROUP_SIZE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ID_W-1:0]      s_axis_tdata,   // [63:0] group key
  input  logic                 s_axis_tuser,   // [0] func
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_D_W-1:0]   m_axis_tdata,   // [1:0] status, [2] complete, [6:3] group_slot,
                                               // [10:7] position, [15:11] member_count,
                                               // [20:16] groups_in_use, [23:21] zero
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned SlotW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned IdxW  = $clog2(NUM_GROUPS + 1);
  localparam int unsigned CntW  = $clog2(MAX_GROUP_SIZE + 1);
  localparam int unsigned EnW   = (IdxW > CFG_W) ? IdxW : CFG_W;
  localparam int unsigned GsW   = (CntW > CFG_W) ? CntW : CFG_W;
  localparam int unsigned EntW  = ID_W + CntW;

  // configuration
  logic [CFG_W-1:0] group_size_q, groups_en_q;
  logic [CntW-1:0]  eff_gs;
  logic [IdxW-1:0]  eff_en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GROUP_SIZE_RST;
      groups_en_q  <= GROUPS_ENABLED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GROUP_SIZE:     group_size_q <= cfg_data_i;
        CFG_GROUPS_ENABLED: groups_en_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (group_size_q == '0) begin
      eff_gs = CntW'(1);
    end else if (GsW'(group_size_q) > GsW'(MAX_GROUP_SIZE)) begin
      eff_gs = CntW'(MAX_GROUP_SIZE);
    end else begin
      eff_gs = CntW'(group_size_q);
    end
    if (groups_en_q == '0) begin
      eff_en = IdxW'(1);
    end else if (EnW'(groups_en_q) > EnW'(NUM_GROUPS)) begin
      eff_en = IdxW'(NUM_GROUPS);
    end else begin
      eff_en = IdxW'(groups_en_q);
    end
  end

  // control and request registers
  state_e          state_q, state_d;
  logic            func_q, inv_q;
  logic [ID_W-1:0] key_q;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            chk_vld_q, chk_vld_d, chk_used_q, chk_used_d;
  logic [SlotW-1:0] chk_idx_q, chk_idx_d;
  logic            match_q, match_d, free_q, free_d;
  logic [SlotW-1:0] match_idx_q, match_idx_d, free_idx_q, free_idx_d;
  logic [CntW-1:0] match_cnt_q, match_cnt_d;
  logic [NUM_GROUPS-1:0] used_q, used_d;
  logic [IdxW-1:0] used_total_q, used_total_d;
  result_t         res_q, res_d;
  logic            out_vld_q, out_vld_d;

  logic            in_fire, out_free, dec_fire, rd_more;
  logic [SlotW-1:0] rd_addr;
  logic [EntW-1:0] rd_data, wr_data;
  logic            wr_en;
  logic [SlotW-1:0] wr_addr;
  logic [CntW-1:0] new_cnt;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;
  assign dec_fire = (state_q == S_DECIDE) && out_free;
  assign rd_more  = rd_idx_q < eff_en;
  assign rd_addr  = rd_idx_q[SlotW-1:0];

  cgt_slot_ram #(
    .DEPTH(NUM_GROUPS),
    .WIDTH(EntW)
  ) u_slot_ram (
    .clk_i    (clk_i),
    .rd_en_i  ((state_q == S_SCAN) && rd_more),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (s_axis_tdata == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match_q || (!rd_more && !chk_vld_q)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // scan bookkeeping
  always_comb begin
    rd_idx_d    = rd_idx_q;
    chk_vld_d   = chk_vld_q;
    chk_used_d  = chk_used_q;
    chk_idx_d   = chk_idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    match_cnt_d = match_cnt_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    if (state_q == S_IDLE) begin
      rd_idx_d  = '0;
      chk_vld_d = 1'b0;
      match_d   = 1'b0;
      free_d    = 1'b0;
    end else if (state_q == S_SCAN) begin
      chk_vld_d = rd_more;
      if (rd_more) begin
        rd_idx_d   = rd_idx_q + IdxW'(1);
        chk_idx_d  = rd_addr;
        chk_used_d = used_q[rd_addr];
        if (!used_q[rd_addr] && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = rd_addr;
        end
      end
      // compare the entry read in the previous cycle
      if (chk_vld_q && chk_used_q && !match_q && (rd_data[CntW +: ID_W] == key_q)) begin
        match_d     = 1'b1;
        match_idx_d = chk_idx_q;
        match_cnt_d = rd_data[CntW-1:0];
      end
    end
  end

  // decide, write back and build the result
  always_comb begin
    res_d         = '0;
    used_d        = used_q;
    used_total_d  = used_total_q;
    wr_en         = 1'b0;
    wr_addr       = match_idx_q;
    new_cnt       = match_cnt_q + CntW'(1);
    res_d.status  = STAT_OK;
    if (inv_q) begin
      res_d.status = STAT_INVALID;
    end else if (func_q == FUNC_ADD) begin
      if (match_q) begin
        if (match_cnt_q >= eff_gs) begin
          res_d.status = STAT_CAPACITY;
        end else begin
          wr_en              = dec_fire;
          res_d.group_slot   = 4'(match_idx_q);
          res_d.position     = 4'(match_cnt_q);
          res_d.member_count = 5'(new_cnt);
          res_d.complete     = (new_cnt == eff_gs);
        end
      end else if (free_q) begin
        // claim the lowest free slot and take its first message
        new_cnt              = CntW'(1);
        wr_en                = dec_fire;
        wr_addr              = free_idx_q;
        used_d[free_idx_q]   = 1'b1;
        used_total_d         = used_total_q + IdxW'(1);
        res_d.group_slot     = 4'(free_idx_q);
        res_d.member_count   = 5'(new_cnt);
        res_d.complete       = (eff_gs == CntW'(1));
      end else begin
        res_d.status = STAT_CAPACITY;
      end
    end else begin
      if (match_q) begin
        used_d[match_idx_q] = 1'b0;
        if (used_total_q != '0) begin
          used_total_d = used_total_q - IdxW'(1);
        end
        res_d.group_slot = 4'(match_idx_q);
      end else begin
        res_d.status = STAT_NOT_FOUND;
      end
    end
    res_d.groups_in_use = 5'(used_total_d);
    wr_data = {key_q, new_cnt};
  end

  // output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (dec_fire) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_D_W - RES_W){1'b0}}, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rd_idx_q     <= '0;
      chk_vld_q    <= 1'b0;
      match_q      <= 1'b0;
      free_q       <= 1'b0;
      used_q       <= '0;
      used_total_q <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      chk_vld_q <= chk_vld_d;
      match_q   <= match_d;
      free_q    <= free_d;
      out_vld_q <= out_vld_d;
      if (dec_fire) begin
        used_q       <= used_d;
        used_total_q <= used_total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_used_q  <= chk_used_d;
    chk_idx_q   <= chk_idx_d;
    match_idx_q <= match_idx_d;
    match_cnt_q <= match_cnt_d;
    free_idx_q  <= free_idx_d;
    if (in_fire) begin
      func_q <= s_axis_tuser;
      key_q  <= s_axis_tdata;
      inv_q  <= (s_axis_tdata == '0);
    end
    if (dec_fire) begin
      res_q <= res_d;
    end
  end

  // checks
  a_total_tracks_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_total_q == IdxW'($countones(used_q)))
    else $error("group count differs from used slots");

  a_write_only_on_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_DECIDE) && !inv_q && (func_q == FUNC_ADD))
    else $error("slot write outside an accepted add");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_q.status != STAT_OK) |->
      !res_q.complete && (res_q.group_slot == '0) && (res_q.member_count == '0))
    else $error("error result carries slot data");

  a_complete_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_fire && res_d.complete |=> res_q.status == STAT_OK && res_q.member_count != '0)
    else $error("completion flagged on a failed add");

endmodule
